// ===== hw/rtl/p1305_pkg.sv =====
// ----------------------------------------------------------------------------
// p1305_pkg : Poly1305 MAC shared definitions
// Limb widths, key clamp masks, config register indexes and the MAC
// unit control struct.
// ----------------------------------------------------------------------------
package p1305_pkg;

    localparam int NLIMBS    = 5;
    localparam int LIMB_W    = 26;  // radix 2^26 limb
    localparam int HLIMB_W   = 27;  // stored accumulator limb
    localparam int ALIMB_W   = 28;  // accumulator plus message limb
    localparam int COEF_W    = 29;  // r limb, or 5 * r limb
    localparam int PROD_W    = ALIMB_W + COEF_W;
    localparam int ACC_W     = 64;  // row sum
    localparam int CARRY_W   = ACC_W - LIMB_W;
    localparam int FOLD_W    = CARRY_W + 4;
    localparam int ROW_W     = 3;
    localparam int CNT_W     = 5;
    localparam int WORD_W    = 64;
    localparam int BLK_W     = 2 * WORD_W;
    localparam int NBYTES    = BLK_W / 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [ROW_W-1:0]  LAST_LIMB = ROW_W'(NLIMBS - 1);
    localparam logic [ROW_W-1:0]  NLIMBS_C  = ROW_W'(NLIMBS);
    localparam logic [LIMB_W-1:0] LIMB_MASK = 26'h3ffffff;
    localparam logic [ALIMB_W-1:0] HIBIT    = ALIMB_W'(1) << 24;
    localparam logic [ALIMB_W-1:0] P_LOW    = ALIMB_W'(5);

    // clamp masks per limb of r
    localparam logic [LIMB_W-1:0] CLAMP_MASK [NLIMBS] = '{
        26'h3ffffff, 26'h3ffff03, 26'h3ffc0ff, 26'h3f03fff, 26'h00fffff
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_R_LOW  = 2'd0,
        CFG_R_HIGH = 2'd1,
        CFG_S_LOW  = 2'd2,
        CFG_S_HIGH = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic start;  // load carry-in plus first product
        logic en;     // add product to running sum
    } t_mac_ctl;

endpackage

// ===== hw/rtl/p1305_blk_if.sv =====
// ----------------------------------------------------------------------------
// p1305_blk_if : message block channel
// One item is a 16-byte block, its byte count and an end-of-message flag.
// ----------------------------------------------------------------------------
interface p1305_blk_if;
    import p1305_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  block_low;
    logic [WORD_W-1:0]  block_high;
    logic [CNT_W-1:0]   byte_count;
    logic               last;

    modport source (output valid, block_low, block_high, byte_count, last,
                    input ready);
    modport sink   (input valid, block_low, block_high, byte_count, last,
                    output ready);
endinterface

// ===== hw/rtl/p1305_tag_if.sv =====
// ----------------------------------------------------------------------------
// p1305_tag_if : tag channel
// One item is a 128-bit tag, little-endian in two halves.
// ----------------------------------------------------------------------------
interface p1305_tag_if;
    import p1305_pkg::*;

    logic               valid;
    logic               ready;
    logic [WORD_W-1:0]  tag_low;
    logic [WORD_W-1:0]  tag_high;

    modport source (output valid, tag_low, tag_high, input ready);
    modport sink   (input valid, tag_low, tag_high, output ready);
endinterface

// ===== hw/rtl/p1305_mac.sv =====
// ----------------------------------------------------------------------------
// p1305_mac : shared multiply-accumulate unit
// One 28x29 product per cycle, summed into a 64-bit row register.
// ----------------------------------------------------------------------------
module p1305_mac (
    input  logic                          i_clk,
    input  p1305_pkg::t_mac_ctl           i_ctl,
    input  logic [p1305_pkg::ALIMB_W-1:0] i_a,
    input  logic [p1305_pkg::COEF_W-1:0]  i_coef,
    input  logic [p1305_pkg::CARRY_W-1:0] i_init,
    output logic [p1305_pkg::ACC_W-1:0]   o_acc
);
    import p1305_pkg::*;

    logic [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  n_acc;

    assign w_prod = PROD_W'(i_a) * PROD_W'(i_coef);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.start) begin
            n_acc = ACC_W'(i_init) + ACC_W'(w_prod);
        end else if (i_ctl.en) begin
            n_acc = r_acc + ACC_W'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;

endmodule

// ===== hw/rtl/poly1305_mac_core.sv =====
// ----------------------------------------------------------------------------
// poly1305_mac_core : Poly1305 one-time MAC, one block per item
// Iterative core: a single multiply-accumulate unit under a sequencer.
// ----------------------------------------------------------------------------
// Use:
//   Write the key before the message: index 0/1 take r (clamped inside),
//   index 2/3 take s. Write the key only while the core is idle.
//   i_blk carries one 16-byte block per item with its byte count and a last
//   flag. A count of 16 or more is a full block; 1..15 is a padded final
//   block and always ends the message; 0 with last set only finalises, 0
//   with last clear is dropped.
//   o_tag carries one 128-bit tag per finished message.
// Timing:
//   The product (h + m) * r is built as 25 limb products on the one
//   multiplier, one per cycle, row carries taken at each row start, then a
//   fold step. Finalising adds three steps (carry, final reduce, pad add).
//   i_blk.ready is high only in idle.
// Reset and stall:
//   Reset clears the key, the accumulator and the tag valid flag.
//   The tag sits in an output register; the core accepts the next block while
//   it waits, and holds in the pad add step only if a second tag is due
//   before the first one is taken.
// ----------------------------------------------------------------------------
module poly1305_mac_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [p1305_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [p1305_pkg::WORD_W-1:0]    i_cfg_data,
    p1305_blk_if.sink                       i_blk,
    p1305_tag_if.source                     o_tag
);
    import p1305_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_FOLD = 6'b000100,
        S_FIN1 = 6'b001000,
        S_FIN2 = 6'b010000,
        S_FIN3 = 6'b100000
    } t_state;

    t_state r_state, n_state;

    // key registers
    logic [WORD_W-1:0] r_key_r_low, r_key_r_high, r_key_s_low, r_key_s_high;

    // accumulator limbs and (h + m) limbs
    logic [HLIMB_W-1:0] r_h [NLIMBS];
    logic [HLIMB_W-1:0] n_h [NLIMBS];
    logic [ALIMB_W-1:0] r_a [NLIMBS];
    logic [ALIMB_W-1:0] n_a [NLIMBS];

    logic [ROW_W-1:0] r_row, n_row, r_col, n_col;
    logic             r_fin, n_fin;

    logic              r_out_valid, n_out_valid;
    logic [WORD_W-1:0] r_tag_low, r_tag_high;

    // --- message padding and limb split ---
    logic [BLK_W-1:0]   w_blk, w_msg;
    logic [ALIMB_W-1:0] w_m [NLIMBS];
    logic               w_full;

    always_comb begin
        w_blk = {i_blk.block_high, i_blk.block_low};
        for (int b = 0; b < NBYTES; b++) begin
            if (i_blk.byte_count > CNT_W'(b)) begin
                w_msg[b*8 +: 8] = w_blk[b*8 +: 8];
            end else if (i_blk.byte_count == CNT_W'(b)) begin
                w_msg[b*8 +: 8] = 8'h01;   // pad byte after short data
            end else begin
                w_msg[b*8 +: 8] = 8'h00;
            end
        end
    end

    assign w_full = (i_blk.byte_count >= CNT_W'(NBYTES));

    always_comb begin
        for (int i = 0; i < NLIMBS - 1; i++) begin
            w_m[i] = ALIMB_W'(w_msg[i*LIMB_W +: LIMB_W]);
        end
        w_m[NLIMBS-1] = ALIMB_W'(w_msg[BLK_W-1:(NLIMBS-1)*LIMB_W])
                      + (w_full ? HIBIT : '0);
    end

    // --- clamped r limbs ---
    logic [BLK_W-1:0]  w_key;
    logic [LIMB_W-1:0] w_r [NLIMBS];

    assign w_key = {r_key_r_high, r_key_r_low};

    always_comb begin
        for (int i = 0; i < NLIMBS - 1; i++) begin
            w_r[i] = w_key[i*LIMB_W +: LIMB_W] & CLAMP_MASK[i];
        end
        w_r[NLIMBS-1] = LIMB_W'(w_key[BLK_W-1:(NLIMBS-1)*LIMB_W])
                      & CLAMP_MASK[NLIMBS-1];
    end

    // --- coefficient select: r[row-col], or 5*r wrapped past the top ---
    logic [ROW_W-1:0]  w_k;
    logic              w_wrap;
    logic [LIMB_W-1:0] w_rk;
    logic [COEF_W-1:0] w_coef;

    assign w_wrap = (r_col > r_row);
    assign w_k    = w_wrap ? (r_row + NLIMBS_C - r_col) : (r_row - r_col);
    assign w_rk   = w_r[w_k];
    assign w_coef = w_wrap ? ((COEF_W'(w_rk) << 2) + COEF_W'(w_rk)) : COEF_W'(w_rk);

    // --- shared MAC unit ---
    t_mac_ctl           w_mac_ctl;
    logic [CARRY_W-1:0] w_init;
    logic [ACC_W-1:0]   w_acc;
    logic [CARRY_W-1:0] w_carry;

    assign w_carry         = w_acc[ACC_W-1:LIMB_W];
    assign w_mac_ctl.start = (r_state == S_MUL) && (r_col == '0);
    assign w_mac_ctl.en    = (r_state == S_MUL);
    assign w_init          = (r_row == '0) ? '0 : w_carry;

    p1305_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_a    (r_a[r_col]),
        .i_coef (w_coef),
        .i_init (w_init),
        .o_acc  (w_acc)
    );

    // --- fold of the top carry: h0 += 5*c ---
    logic [FOLD_W-1:0] w_fold;
    assign w_fold = FOLD_W'(r_h[0]) + (FOLD_W'(w_carry) << 2) + FOLD_W'(w_carry);

    // --- finalise step 1: carry pass ---
    logic [ALIMB_W-1:0] f1_0, f1_1, f1_2, f1_3, f1_4, f1_0b;
    always_comb begin
        f1_1  = ALIMB_W'(r_h[1][LIMB_W-1:0]);
        f1_2  = ALIMB_W'(r_h[2]) + (ALIMB_W'(r_h[1]) >> LIMB_W);
        f1_3  = ALIMB_W'(r_h[3]) + (f1_2 >> LIMB_W);
        f1_4  = ALIMB_W'(r_h[4]) + (f1_3 >> LIMB_W);
        f1_0  = ALIMB_W'(r_h[0]) + ((f1_4 >> LIMB_W) << 2) + (f1_4 >> LIMB_W);
        f1_0b = f1_1 + (f1_0 >> LIMB_W);
    end

    // --- finalise step 2: take h + 5 - 2^130 when not negative ---
    logic [ALIMB_W-1:0] g0, g1, g2, g3, g4;
    logic               w_take_g;
    always_comb begin
        g0 = ALIMB_W'(r_h[0]) + P_LOW;
        g1 = ALIMB_W'(r_h[1]) + (g0 >> LIMB_W);
        g2 = ALIMB_W'(r_h[2]) + (g1 >> LIMB_W);
        g3 = ALIMB_W'(r_h[3]) + (g2 >> LIMB_W);
        g4 = ALIMB_W'(r_h[4]) + (g3 >> LIMB_W);
    end
    assign w_take_g = (g4[ALIMB_W-1:LIMB_W] != '0);

    // --- finalise step 3: pack and add s ---
    logic [WORD_W-1:0] w_lo, w_hi;
    logic [WORD_W:0]   w_sum_lo;
    logic [WORD_W-1:0] w_sum_hi;
    logic              w_out_free;

    assign w_lo = WORD_W'(r_h[0]) | (WORD_W'(r_h[1]) << 26) | (WORD_W'(r_h[2]) << 52);
    assign w_hi = (WORD_W'(r_h[2]) >> 12) | (WORD_W'(r_h[3]) << 14)
                | (WORD_W'(r_h[4]) << 40);
    assign w_sum_lo = {1'b0, w_lo} + {1'b0, r_key_s_low};
    assign w_sum_hi = w_hi + r_key_s_high + WORD_W'(w_sum_lo[WORD_W]);
    assign w_out_free = !r_out_valid || o_tag.ready;

    // --- sequencer ---
    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_a         = r_a;
        n_row       = r_row;
        n_col       = r_col;
        n_fin       = r_fin;
        n_out_valid = r_out_valid && !o_tag.ready;

        case (r_state)
            S_IDLE: begin
                if (i_blk.valid) begin
                    if (i_blk.byte_count != '0) begin
                        for (int i = 0; i < NLIMBS; i++) begin
                            n_a[i] = ALIMB_W'(r_h[i]) + w_m[i];
                        end
                        n_row   = '0;
                        n_col   = '0;
                        n_fin   = !w_full || i_blk.last;
                        n_state = S_MUL;
                    end else if (i_blk.last) begin
                        n_state = S_FIN1;
                    end
                end
            end
            S_MUL: begin
                // previous row sum is complete at each row start
                if (r_col == '0 && r_row != '0) begin
                    n_h[r_row - ROW_W'(1)] = HLIMB_W'(w_acc[LIMB_W-1:0]);
                end
                if (r_col == LAST_LIMB) begin
                    n_col = '0;
                    if (r_row == LAST_LIMB) begin
                        n_state = S_FOLD;
                    end else begin
                        n_row = r_row + ROW_W'(1);
                    end
                end else begin
                    n_col = r_col + ROW_W'(1);
                end
            end
            S_FOLD: begin
                n_h[NLIMBS-1] = HLIMB_W'(w_acc[LIMB_W-1:0]);
                n_h[0]        = HLIMB_W'(w_fold[LIMB_W-1:0]);
                n_h[1]        = r_h[1] + HLIMB_W'(w_fold[FOLD_W-1:LIMB_W]);
                n_state       = r_fin ? S_FIN1 : S_IDLE;
            end
            S_FIN1: begin
                n_h[0]  = HLIMB_W'(f1_0[LIMB_W-1:0]);
                n_h[1]  = HLIMB_W'(f1_0b);
                n_h[2]  = HLIMB_W'(f1_2[LIMB_W-1:0]);
                n_h[3]  = HLIMB_W'(f1_3[LIMB_W-1:0]);
                n_h[4]  = HLIMB_W'(f1_4[LIMB_W-1:0]);
                n_state = S_FIN2;
            end
            S_FIN2: begin
                if (w_take_g) begin
                    n_h[0] = HLIMB_W'(g0[LIMB_W-1:0]);
                    n_h[1] = HLIMB_W'(g1[LIMB_W-1:0]);
                    n_h[2] = HLIMB_W'(g2[LIMB_W-1:0]);
                    n_h[3] = HLIMB_W'(g3[LIMB_W-1:0]);
                    n_h[4] = HLIMB_W'(g4[LIMB_W-1:0]);
                end
                n_state = S_FIN3;
            end
            S_FIN3: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    for (int i = 0; i < NLIMBS; i++) begin
                        n_h[i] = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_row        <= '0;
            r_col        <= '0;
            r_fin        <= 1'b0;
            r_out_valid  <= 1'b0;
            r_key_r_low  <= '0;
            r_key_r_high <= '0;
            r_key_s_low  <= '0;
            r_key_s_high <= '0;
            for (int i = 0; i < NLIMBS; i++) begin
                r_h[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_col       <= n_col;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
            r_h         <= n_h;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_R_LOW:  r_key_r_low  <= i_cfg_data;
                    CFG_R_HIGH: r_key_r_high <= i_cfg_data;
                    CFG_S_LOW:  r_key_s_low  <= i_cfg_data;
                    CFG_S_HIGH: r_key_s_high <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // operand and tag registers, no reset
    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        if (r_state == S_FIN3 && w_out_free) begin
            r_tag_low  <= w_sum_lo[WORD_W-1:0];
            r_tag_high <= w_sum_hi;
        end
    end

    assign i_blk.ready    = (r_state == S_IDLE);
    assign o_tag.valid    = r_out_valid;
    assign o_tag.tag_low  = r_tag_low;
    assign o_tag.tag_high = r_tag_high;

    // --- checks ---
    a_tag_from_pad_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FIN3))
        else $error("tag raised outside pad add step");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN3 && r_out_valid && !o_tag.ready) |=> (r_state == S_FIN3))
        else $error("pad add step left while output full");

    a_mul_to_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL && r_row == LAST_LIMB && r_col == LAST_LIMB)
        |=> (r_state == S_FOLD))
        else $error("last limb product not followed by fold");

    a_counter_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_row <= LAST_LIMB && r_col <= LAST_LIMB))
        else $error("limb counter out of range");

endmodule
